// ===== sv/bounce_settle_animator_unit_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef BOUNCE_SETTLE_ANIMATOR_UNIT_MACROS_SVH
`define BOUNCE_SETTLE_ANIMATOR_UNIT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define BSA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
    else $error("bsa assertion failed");

// Clocked assertion that is also checked during reset.
`define BSA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bsa assertion failed");

`endif

// ===== sv/bsa_pkg.sv =====
package bsa_pkg;

  localparam int unsigned LevelW   = 8;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] RegStartMode   = 3'd0;
  localparam logic [2:0] RegStartTarget = 3'd1;
  localparam logic [2:0] RegStartLow    = 3'd2;
  localparam logic [2:0] RegStartHigh   = 3'd3;
  localparam logic [2:0] RegRestValue   = 3'd4;
  localparam logic [2:0] RegStartStep   = 3'd5;
  localparam logic [2:0] RegRampStep    = 3'd6;
  localparam logic [2:0] RegStartDelay  = 3'd7;

  // Item operations
  typedef enum logic {
    OpTick  = 1'b0,
    OpStart = 1'b1
  } anim_op_e;

  // Animation modes
  localparam logic [ModeW-1:0] ModeIdle   = 3'd0;
  localparam logic [ModeW-1:0] ModeFinish = 3'd1;
  localparam logic [ModeW-1:0] ModeBounce = 3'd2;
  localparam logic [ModeW-1:0] ModeSettle = 3'd3;
  localparam logic [ModeW-1:0] ModeOsc    = 3'd4;
  localparam logic [ModeW-1:0] ModeRamp   = 3'd5;
  localparam logic [ModeW-1:0] ModeWait   = 3'd7;

  // Bound shrink amounts and settle thresholds
  localparam logic [LevelW-1:0] DropWide     = 8'd30;
  localparam logic [LevelW-1:0] DropNarrow   = 8'd10;
  localparam logic [LevelW-1:0] SettleSwitch = 8'd90;
  localparam logic [LevelW-1:0] SettleKnee   = 8'd150;
  localparam logic [LevelW-1:0] SettleHalve  = 8'd120;

  typedef struct packed {
    logic [ModeW-1:0]         start_mode;
    logic [LevelW-1:0]        start_target;
    logic [LevelW-1:0]        start_low;
    logic [LevelW-1:0]        start_high;
    logic [LevelW-1:0]        rest_value;
    logic signed [LevelW-1:0] start_step;
    logic signed [LevelW-1:0] ramp_step;
    logic [LevelW-1:0]        start_delay;
  } cfg_t;

  typedef struct packed {
    logic [ModeW-1:0]         mode;
    logic [LevelW-1:0]        turn_point;
    logic [LevelW-1:0]        low_bound;
    logic [LevelW-1:0]        high_bound;
    logic signed [LevelW-1:0] step;
    logic [LevelW-1:0]        delay_left;
    logic [LevelW-1:0]        level;
  } state_t;

endpackage

// ===== sv/bsa_if.sv =====
// Input item channel
interface bsa_in_if import bsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [LevelW-1:0] start_level;

  modport source (output valid, operation, start_level, input ready);
  modport sink   (input valid, operation, start_level, output ready);
endinterface

// Result item channel
interface bsa_out_if import bsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] level;
  logic [ModeW-1:0]  mode_out;

  modport source (output valid, level, mode_out, input ready);
  modport sink   (input valid, level, mode_out, output ready);
endinterface

// ===== sv/bsa_cfg.sv =====
module bsa_cfg import bsa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CfgAddrW-1:2];
  assign cfg_o   = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        RegStartMode:   cfg_q.start_mode   <= pwdata[ModeW-1:0];
        RegStartTarget: cfg_q.start_target <= pwdata[LevelW-1:0];
        RegStartLow:    cfg_q.start_low    <= pwdata[LevelW-1:0];
        RegStartHigh:   cfg_q.start_high   <= pwdata[LevelW-1:0];
        RegRestValue:   cfg_q.rest_value   <= pwdata[LevelW-1:0];
        RegStartStep:   cfg_q.start_step   <= pwdata[LevelW-1:0];
        RegRampStep:    cfg_q.ramp_step    <= pwdata[LevelW-1:0];
        RegStartDelay:  cfg_q.start_delay  <= pwdata[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (reg_idx)
      RegStartMode:   prdata[ModeW-1:0]  = cfg_q.start_mode;
      RegStartTarget: prdata[LevelW-1:0] = cfg_q.start_target;
      RegStartLow:    prdata[LevelW-1:0] = cfg_q.start_low;
      RegStartHigh:   prdata[LevelW-1:0] = cfg_q.start_high;
      RegRestValue:   prdata[LevelW-1:0] = cfg_q.rest_value;
      RegStartStep:   prdata[LevelW-1:0] = cfg_q.start_step;
      RegRampStep:    prdata[LevelW-1:0] = cfg_q.ramp_step;
      RegStartDelay:  prdata[LevelW-1:0] = cfg_q.start_delay;
      default: ;
    endcase
  end

endmodule

// ===== sv/bsa_step.sv =====
module bsa_step import bsa_pkg::*; (
  input  state_t            state_i,
  input  cfg_t              cfg_i,
  input  logic              operation_i,
  input  logic [LevelW-1:0] start_level_i,
  output state_t            state_o
);

  function automatic logic is_pos(input logic [LevelW-1:0] s);
    return (s != '0) && !s[LevelW-1];
  endfunction

  function automatic logic [LevelW-1:0] drop_floor(input logic [LevelW-1:0] v,
                                                   input logic [LevelW-1:0] amt);
    return (v > amt) ? (v - amt) : '0;
  endfunction

  state_t            nx;
  logic [LevelW-1:0] amount;

  assign state_o = nx;

  always_comb begin
    nx     = state_i;
    amount = DropWide;
    if (operation_i == OpStart) begin
      // start: load everything, no tick
      nx.level      = start_level_i;
      nx.mode       = cfg_i.start_mode;
      nx.turn_point = cfg_i.start_target;
      nx.low_bound  = cfg_i.start_low;
      nx.high_bound = cfg_i.start_high;
      nx.step       = cfg_i.start_step;
      nx.delay_left = cfg_i.start_delay;
    end else begin
      // turning point action
      if (state_i.level == state_i.turn_point) begin
        case (state_i.mode)
          ModeFinish: begin
            nx.mode = (state_i.delay_left != '0) ? ModeWait : ModeIdle;
          end
          ModeBounce: begin
            if (state_i.high_bound == state_i.low_bound) begin
              nx.mode = ModeIdle;
            end else begin
              nx.low_bound  = drop_floor(state_i.low_bound, DropWide);
              nx.high_bound = drop_floor(state_i.high_bound, DropWide);
              nx.turn_point = is_pos(state_i.step) ? nx.high_bound : nx.low_bound;
              nx.step       = -state_i.step;
            end
          end
          ModeSettle: begin
            if (state_i.high_bound == state_i.low_bound) begin
              nx.mode = ModeIdle;
            end else if (state_i.low_bound == SettleSwitch) begin
              nx.mode       = ModeFinish;
              nx.step       = '1;
              nx.turn_point = '0;
            end else begin
              amount        = (state_i.low_bound <= SettleKnee) ? DropNarrow : DropWide;
              nx.low_bound  = drop_floor(state_i.low_bound, amount);
              nx.high_bound = drop_floor(state_i.high_bound, amount);
              nx.turn_point = is_pos(state_i.step) ? nx.high_bound : nx.low_bound;
              nx.step       = -state_i.step;
              if (nx.low_bound == SettleHalve) begin
                nx.step = {nx.step[LevelW-1], nx.step[LevelW-1:1]};
              end
            end
          end
          ModeOsc: begin
            nx.turn_point = is_pos(state_i.step) ? state_i.high_bound : state_i.low_bound;
            nx.step       = -state_i.step;
          end
          ModeRamp: begin
            nx.mode       = ModeFinish;
            nx.turn_point = cfg_i.rest_value;
            nx.step       = cfg_i.ramp_step;
            if (is_pos(cfg_i.ramp_step)) begin
              if (cfg_i.rest_value <= state_i.level) nx.mode = ModeIdle;
            end else if (cfg_i.rest_value >= state_i.level) begin
              nx.mode = ModeIdle;
            end
          end
          default: ;
        endcase
      end
      // delay countdown or step advance
      if (nx.mode != ModeIdle) begin
        if (nx.delay_left != '0) begin
          if (nx.delay_left == 8'd1) begin
            nx.level = cfg_i.rest_value;
            nx.mode  = ModeFinish;
          end
          nx.delay_left = nx.delay_left - 8'd1;
        end else begin
          nx.level = nx.level + $unsigned(nx.step);
        end
      end
    end
  end

endmodule

// ===== sv/bounce_settle_animator_unit.sv =====
// An item passes the input register, then the state/result register.
// One item per cycle if results are taken; the state update is a single byte-wide pass.
// Reset (rst_ni low, asynchronous): animator state, configuration registers and all valid
// flags clear to zero; no item is held and no result is shown.
// A stalled result holds the input register; ready follows the result side combinationally.
module bounce_settle_animator_unit import bsa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  bsa_in_if.sink              in_i,
  bsa_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t              cfg;
  state_t            state_q, state_d;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_op_q;
  logic [LevelW-1:0] s1_level_q;
  logic              out_valid_q, out_valid_d;
  logic              advance;
  logic              in_acc;

  bsa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bsa_step u_step (
    .state_i       (state_q),
    .cfg_i         (cfg),
    .operation_i   (s1_op_q),
    .start_level_i (s1_level_q),
    .state_o       (state_d)
  );

  // Handshake control
  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  // Valid flags and animator state (state doubles as the result register)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_valid_q && advance) begin
        state_q <= state_d;
      end
    end
  end

  // Input item register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q    <= in_i.operation;
      s1_level_q <= in_i.start_level;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.level    = state_q.level;
  assign out_o.mode_out = state_q.mode;

endmodule

// ===== sv/bsa_chk.sv =====
`include "bounce_settle_animator_unit_macros.svh"

module bsa_chk import bsa_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [LevelW-1:0]   out_level,
  input logic [ModeW-1:0]    out_mode,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [CfgAddrW-1:0] paddr,
  input logic [CfgDataW-1:0] pwdata,
  input logic [CfgDataW-1:0] prdata
);

  logic in_acc;
  logic cfg_wr;

  assign in_acc = in_valid && in_ready;
  assign cfg_wr = psel && penable && pwrite;

  // nothing is shown while in reset
  `BSA_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid)

  // a stalled result holds
  `BSA_ASSERT(a_out_hold, clk_i, rst_ni,
      (out_valid && !out_ready) |=> (out_valid && $stable(out_level) && $stable(out_mode)))

  // no result appears without an item accepted ahead of it
  `BSA_ASSERT(a_no_phantom, clk_i, rst_ni,
      (!out_valid && !in_acc && !$past(in_acc)) |=> !out_valid)

  // a register read right after a write returns the written low bits
  `BSA_ASSERT(a_cfg_readback, clk_i, rst_ni,
      cfg_wr ##1 (psel && !pwrite && paddr == $past(paddr))
        |-> prdata[ModeW-1:0] == $past(pwdata[ModeW-1:0]))

endmodule

bind bounce_settle_animator_unit bsa_chk u_bsa_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_level (out_o.level),
  .out_mode  (out_o.mode_out),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
